/* src/utf_pkg.sv */
package utf_pkg;

   // Encoding codes of the format registers; code three acts as UTF-32
   localparam logic [1:0] FMT_UTF8  = 2'd0;
   localparam logic [1:0] FMT_UTF16 = 2'd1;
   localparam logic [1:0] FMT_UTF32 = 2'd2;

   // Error kinds carried on the result channel
   localparam logic [1:0] ERR_NONE      = 2'd0;
   localparam logic [1:0] ERR_BAD_LEAD  = 2'd1;
   localparam logic [1:0] ERR_LONE_LOW  = 2'd2;
   localparam logic [1:0] ERR_TOO_LARGE = 2'd3;

   // Configuration register indexes
   localparam logic CSR_INPUT_FORMAT  = 1'b0;
   localparam logic CSR_OUTPUT_FORMAT = 1'b1;

   localparam int CP_WIDTH = 21;
   localparam logic [CP_WIDTH-1:0] CP_MAX = 21'h10FFFF;

   // One decoded code point or error, as queued between front and back
   typedef struct packed {
      logic [1:0]          err;
      logic [CP_WIDTH-1:0] cp;
   } entry_type;

   // Queue status seen by the front and the back
   typedef struct packed {
      logic full;
      logic valid;
   } queue_status_type;

endpackage

/* src/unicode_utf_transcoder.sv */
// UTF-8 / UTF-16 / UTF-32 transcoder. Each request carries one code unit in the
// encoding set by register 0 (input_format: 0 UTF-8, 1 UTF-16, 2 or 3 UTF-32);
// each code point comes out as one to four units in the encoding set by
// register 1 (output_format, same codes, reset UTF-32), with rsp_tlast on the
// final unit. rsp_tuser carries the error kind (1 bad UTF-8 lead byte, 2 lone
// low surrogate, 3 value above 0x10FFFF); an error is a single zero unit with
// rsp_tlast set. Continuation bytes and low surrogates are not checked. A
// register write clears any partial sequence; write registers only while the
// block is idle. Requests are taken at one per cycle while the queue of
// QUEUE_DEPTH decoded code points has room; the encoder drains one unit per
// cycle while rsp_tready is high, so a code point takes one to four output
// units and that encoder sets the sustained rate when outputs are multi-unit.
module unicode_utf_transcoder import utf_pkg::*; #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] in_unit
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [20:0] out_unit, [23:21] zero
   output logic        rsp_tlast,   // last_of_run
   output logic [1:0]  rsp_tuser,   // [1:0] error_kind
   // configuration write channel
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [1:0]  csr_data
);

   logic [1:0]          in_fmt_ff, in_fmt_in;
   logic [1:0]          out_fmt_ff, out_fmt_in;
   logic                csr_write;
   logic                accept;
   logic                push, pop;
   entry_type           push_entry, head;
   queue_status_type    status;
   logic [CP_WIDTH-1:0] out_unit;

   assign csr_ready  = 1'b1;
   assign csr_write  = csr_valid && csr_ready;
   assign req_tready = !status.full;
   assign accept     = req_tvalid && req_tready;

   // Update the format registers
   always_comb begin
      in_fmt_in  = in_fmt_ff;
      out_fmt_in = out_fmt_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_INPUT_FORMAT:  in_fmt_in  = csr_data;
            CSR_OUTPUT_FORMAT: out_fmt_in = csr_data;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_fmt_ff  <= FMT_UTF8;
         out_fmt_ff <= FMT_UTF32;
      end else begin
         in_fmt_ff  <= in_fmt_in;
         out_fmt_ff <= out_fmt_in;
      end
   end

   utf_front u_front (
      .clock         (clock),
      .reset         (reset),
      .input_format  (in_fmt_ff),
      .clear_partial (csr_write),
      .accept        (accept),
      .in_unit       (req_tdata),
      .push          (push),
      .push_entry    (push_entry)
   );

   utf_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .status     (status),
      .head       (head)
   );

   utf_back u_back (
      .clock         (clock),
      .reset         (reset),
      .output_format (out_fmt_ff),
      .status        (status),
      .head          (head),
      .out_ready     (rsp_tready),
      .pop           (pop),
      .out_valid     (rsp_tvalid),
      .out_unit      (out_unit),
      .out_last      (rsp_tlast),
      .out_err       (rsp_tuser)
   );

   assign rsp_tdata = {3'b0, out_unit};

endmodule

/* src/utf_front.sv */
module utf_front import utf_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic [1:0]       input_format,
   input  logic             clear_partial,
   input  logic             accept,
   input  logic [31:0]      in_unit,
   output logic             push,
   output entry_type        push_entry
);

   logic [1:0]          exp_ff, exp_in;
   logic [CP_WIDTH-1:0] part_ff, part_in;
   logic [7:0]          b;
   logic [15:0]         u;
   logic [CP_WIDTH-1:0] cont_cp;
   logic [CP_WIDTH-1:0] surr_cp;

   assign b       = in_unit[7:0];
   assign u       = in_unit[15:0];
   assign cont_cp = {part_ff[CP_WIDTH-7:0], b[5:0]};
   assign surr_cp = 21'h10000 + {1'b0, part_ff[19:10], 10'b0} + {11'b0, u[9:0]};

   // Classify the request and advance the sequence state
   always_comb begin
      exp_in          = exp_ff;
      part_in         = part_ff;
      push            = 1'b0;
      push_entry.err  = ERR_NONE;
      push_entry.cp   = '0;
      if (clear_partial) begin
         exp_in  = '0;
         part_in = '0;
      end else if (accept) begin
         unique case (input_format)
            FMT_UTF8: begin
               if (exp_ff == 2'd0) begin
                  priority if (!b[7]) begin
                     push          = 1'b1;
                     push_entry.cp = {13'b0, b};
                  end else if (b[7:5] == 3'b110) begin
                     part_in = {16'b0, b[4:0]};
                     exp_in  = 2'd1;
                  end else if (b[7:4] == 4'b1110) begin
                     part_in = {17'b0, b[3:0]};
                     exp_in  = 2'd2;
                  end else if (b[7:3] == 5'b11110) begin
                     part_in = {18'b0, b[2:0]};
                     exp_in  = 2'd3;
                  end else begin
                     push           = 1'b1;
                     push_entry.err = ERR_BAD_LEAD;
                     part_in        = '0;
                  end
               end else begin
                  exp_in  = exp_ff - 2'd1;
                  part_in = cont_cp;
                  if (exp_ff == 2'd1) begin
                     push    = 1'b1;
                     part_in = '0;
                     if (cont_cp > CP_MAX) push_entry.err = ERR_TOO_LARGE;
                     else                  push_entry.cp  = cont_cp;
                  end
               end
            end
            FMT_UTF16: begin
               if (exp_ff == 2'd0) begin
                  priority if (u[15:10] == 6'b110110) begin
                     part_in = {1'b0, u[9:0], 10'b0};
                     exp_in  = 2'd1;
                  end else if (u[15:10] == 6'b110111) begin
                     push           = 1'b1;
                     push_entry.err = ERR_LONE_LOW;
                     part_in        = '0;
                  end else begin
                     push          = 1'b1;
                     push_entry.cp = {5'b0, u};
                  end
               end else begin
                  push          = 1'b1;
                  push_entry.cp = surr_cp;
                  exp_in        = '0;
                  part_in       = '0;
               end
            end
            default: begin
               push    = 1'b1;
               exp_in  = '0;
               part_in = '0;
               if (in_unit > {11'b0, CP_MAX}) push_entry.err = ERR_TOO_LARGE;
               else                           push_entry.cp  = in_unit[CP_WIDTH-1:0];
            end
         endcase
      end
   end

   // Hold the sequence state
   always_ff @(posedge clock) begin
      if (reset) begin
         exp_ff  <= '0;
         part_ff <= '0;
      end else begin
         exp_ff  <= exp_in;
         part_ff <= part_in;
      end
   end

endmodule

/* src/utf_queue.sv */
module utf_queue import utf_pkg::*; #(
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  entry_type        push_entry,
   input  logic             pop,
   output queue_status_type status,
   output entry_type        head
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

   entry_type       mem_ff [DEPTH];
   logic [PW-1:0]   wr_ff, wr_in, rd_ff, rd_in;
   logic [CW-1:0]   cnt_ff, cnt_in;
   logic            do_push, do_pop;

   assign status.full  = (cnt_ff == CW'(DEPTH));
   assign status.valid = (cnt_ff != '0);
   assign do_push      = push && !status.full;
   assign do_pop       = pop && status.valid;
   assign head         = mem_ff[rd_ff];

   // Advance pointers with wrap at the depth
   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (do_push) wr_in = (wr_ff == LAST_PTR) ? '0 : wr_ff + PW'(1);
      if (do_pop)  rd_in = (rd_ff == LAST_PTR) ? '0 : rd_ff + PW'(1);
      if (do_push && !do_pop)      cnt_in = cnt_ff + CW'(1);
      else if (do_pop && !do_push) cnt_in = cnt_ff - CW'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   // Store the pushed entry
   always_ff @(posedge clock) begin
      if (do_push) mem_ff[wr_ff] <= push_entry;
   end

endmodule

/* src/utf_back.sv */
module utf_back import utf_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic [1:0]          output_format,
   input  queue_status_type    status,
   input  entry_type           head,
   input  logic                out_ready,
   output logic                pop,
   output logic                out_valid,
   output logic [CP_WIDTH-1:0] out_unit,
   output logic                out_last,
   output logic [1:0]          out_err
);

   logic [1:0]          idx_ff, idx_in;
   logic [1:0]          last_idx;
   logic [CP_WIDTH-1:0] cp;
   logic [19:0]         v;
   logic                taken;

   assign cp    = head.cp;
   assign v     = 20'(cp - 21'h10000);
   assign taken = out_valid && out_ready;

   // Select the unit at the current position of the code point
   always_comb begin
      last_idx = 2'd0;
      out_unit = cp;
      unique case (output_format)
         FMT_UTF8: begin
            priority if (cp <= 21'h7F) begin
               last_idx = 2'd0;
               out_unit = cp;
            end else if (cp <= 21'h7FF) begin
               last_idx = 2'd1;
               unique case (idx_ff)
                  2'd0:    out_unit = {13'b0, 3'b110, cp[10:6]};
                  default: out_unit = {13'b0, 2'b10, cp[5:0]};
               endcase
            end else if (cp <= 21'hFFFF) begin
               last_idx = 2'd2;
               unique case (idx_ff)
                  2'd0:    out_unit = {13'b0, 4'b1110, cp[15:12]};
                  2'd1:    out_unit = {13'b0, 2'b10, cp[11:6]};
                  default: out_unit = {13'b0, 2'b10, cp[5:0]};
               endcase
            end else begin
               last_idx = 2'd3;
               unique case (idx_ff)
                  2'd0:    out_unit = {13'b0, 5'b11110, cp[20:18]};
                  2'd1:    out_unit = {13'b0, 2'b10, cp[17:12]};
                  2'd2:    out_unit = {13'b0, 2'b10, cp[11:6]};
                  default: out_unit = {13'b0, 2'b10, cp[5:0]};
               endcase
            end
         end
         FMT_UTF16: begin
            if (cp < 21'h10000) begin
               last_idx = 2'd0;
               out_unit = cp;
            end else begin
               last_idx = 2'd1;
               if (idx_ff == 2'd0) out_unit = {5'b0, 6'b110110, v[19:10]};
               else                out_unit = {5'b0, 6'b110111, v[9:0]};
            end
         end
         default: begin
            last_idx = 2'd0;
            out_unit = cp;
         end
      endcase
      if (head.err != ERR_NONE) begin
         last_idx = 2'd0;
         out_unit = '0;
      end
   end

   assign out_valid = status.valid;
   assign out_err   = head.err;
   assign out_last  = (idx_ff == last_idx);
   assign pop       = taken && out_last;
   assign idx_in    = pop ? 2'd0 : (taken ? idx_ff + 2'd1 : idx_ff);

   // Advance the unit position, drop the entry after its last unit
   always_ff @(posedge clock) begin
      if (reset) idx_ff <= '0;
      else       idx_ff <= idx_in;
   end

endmodule
